>>> design/u8g_pkg.sv
// u8g_pkg: shared types and constants for the utf-8 to glyph decoder
// no dependencies; imported by u8g_ctrl, u8g_dp and utf8_decode_to_glyph
package u8g_pkg;

  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned TdataOutWidth = 128;

  localparam logic OpData  = 1'b0;
  localparam logic OpFlush = 1'b1;

  localparam logic [20:0] ReplCp    = 21'h00FFFD;
  localparam logic [20:0] MaxScalar = 21'h10FFFF;
  localparam logic [20:0] SurLo     = 21'h00D800;
  localparam logic [20:0] SurHi     = 21'h00DFFF;
  localparam logic [20:0] NonCharFe = 21'h00FFFE;
  localparam logic [20:0] NonCharFf = 21'h00FFFF;
  localparam logic [20:0] Min2Byte  = 21'h000080;
  localparam logic [20:0] Min3Byte  = 21'h000800;
  localparam logic [20:0] Min4Byte  = 21'h010000;

  typedef struct packed {
    logic take;
    logic load;
  } u8g_cmd_t;

  typedef struct packed {
    logic plan_any;
    logic pend_any;
  } u8g_sts_t;

endpackage

>>> design/u8g_ctrl.sv
// u8g_ctrl: controller state machine for the utf-8 to glyph decoder
// depends on u8g_pkg; drives u8g_dp through command and status structs
module u8g_ctrl import u8g_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  u8g_sts_t sts_i,
  output u8g_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StLoad = 3'b010,
    StShow = 3'b100
  } u8g_state_e;

  u8g_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.plan_any) state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d    = StShow;
      end
      StShow: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.pend_any) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output sides active together");
  a_take_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take && sts_i.plan_any |=> state_q == StLoad)
    else $error("item with results did not start loading");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o) else $error("loaded result not shown");

endmodule

>>> design/u8g_dp.sv
// u8g_dp: datapath of the utf-8 to glyph decoder: sequence buffer, result plan,
// saturating totals and output register; depends on u8g_pkg
module u8g_dp import u8g_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  u8g_cmd_t    cmd_i,
  output u8g_sts_t    sts_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic [20:0] code_point_o,
  output logic        well_formed_o,
  output logic [7:0]  glyph_code_o,
  output logic        glyph_fallback_o,
  output logic        last_of_run_o,
  output logic [31:0] decoded_total_o,
  output logic [31:0] invalid_total_o,
  output logic [31:0] replacement_total_o
);

  function automatic logic [7:0] glyph_of(input logic [20:0] cp);
    logic [7:0] g;
    g = 8'h00;
    if (cp < 21'h80) begin
      g = cp[7:0];
    end else begin
      case (cp)
        21'h0000E4: g = 8'h84;
        21'h0000F6: g = 8'h94;
        21'h0000FC: g = 8'h81;
        21'h0000C4: g = 8'h8E;
        21'h0000D6: g = 8'h99;
        21'h0000DC: g = 8'h9A;
        21'h0000DF: g = 8'hE1;
        default:    g = 8'h00;
      endcase
    end
    return g;
  endfunction

  // sequence buffer
  logic [7:0]  b0_q, b1_q, b2_q;
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  exp_q, exp_d;
  logic        wr_b0, wr_b1, wr_b2;

  // result plan of the current item
  logic [2:0]  rep_q, rep_d;
  logic        tail_q, tail_d;
  logic [20:0] tail_cp_q, tail_cp_d;
  logic        tail_ok_q, tail_ok_d;

  logic [COUNT_WIDTH-1:0] dec_q, inv_q, repl_q;
  logic [COUNT_WIDTH-1:0] dec_d, inv_d, repl_d;
  logic [63:0] dec_x, inv_x, repl_x;

  logic        busy, is_cont, take_lead;
  logic [20:0] cp2, cp3, cp4, fin_cp;
  logic        fin_ok;
  logic [20:0] res_cp;
  logic        res_ok, res_last;

  assign busy = (exp_q >= 3'd2) && (exp_q <= 3'd4) && (cnt_q != 2'd0) &&
                ({1'b0, cnt_q} < exp_q);
  assign is_cont = (data_byte_i[7:6] == 2'b10);

  assign cp2 = {10'd0, b0_q[4:0], data_byte_i[5:0]};
  assign cp3 = {5'd0, b0_q[3:0], b1_q[5:0], data_byte_i[5:0]};
  assign cp4 = {b0_q[2:0], b1_q[5:0], b2_q[5:0], data_byte_i[5:0]};

  always_comb begin
    case (exp_q)
      3'd2: begin
        fin_cp = cp2;
        fin_ok = cp2 >= Min2Byte;
      end
      3'd3: begin
        fin_cp = cp3;
        fin_ok = (cp3 >= Min3Byte) && !((cp3 >= SurLo) && (cp3 <= SurHi)) &&
                 (cp3 != NonCharFe) && (cp3 != NonCharFf);
      end
      default: begin
        fin_cp = cp4;
        fin_ok = (cp4 >= Min4Byte) && (cp4 <= MaxScalar);
      end
    endcase
  end

  always_comb begin
    rep_d     = 3'd0;
    tail_d    = 1'b0;
    tail_cp_d = {13'd0, data_byte_i};
    tail_ok_d = 1'b1;
    cnt_d     = cnt_q;
    exp_d     = exp_q;
    wr_b0     = 1'b0;
    wr_b1     = 1'b0;
    wr_b2     = 1'b0;
    take_lead = 1'b0;
    if (!busy) begin
      cnt_d = 2'd0;
      exp_d = 3'd0;
    end
    if (op_i == OpFlush) begin
      if (busy) rep_d = {1'b0, cnt_q};
      cnt_d = 2'd0;
      exp_d = 3'd0;
    end else if (!busy) begin
      take_lead = 1'b1;
    end else if (is_cont) begin
      if ({1'b0, cnt_q} + 3'd1 == exp_q) begin
        if (fin_ok) begin
          tail_d    = 1'b1;
          tail_cp_d = fin_cp;
        end else begin
          rep_d = exp_q;
        end
        cnt_d = 2'd0;
        exp_d = 3'd0;
      end else begin
        wr_b1 = (cnt_q == 2'd1);
        wr_b2 = (cnt_q == 2'd2);
        cnt_d = cnt_q + 2'd1;
      end
    end else begin
      rep_d     = {1'b0, cnt_q};
      cnt_d     = 2'd0;
      exp_d     = 3'd0;
      take_lead = 1'b1;
    end
    if (take_lead) begin
      if (!data_byte_i[7]) begin
        tail_d = 1'b1;
      end else if (data_byte_i[7:5] == 3'b110) begin
        wr_b0 = 1'b1;
        cnt_d = 2'd1;
        exp_d = 3'd2;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        wr_b0 = 1'b1;
        cnt_d = 2'd1;
        exp_d = 3'd3;
      end else if (data_byte_i[7:3] == 5'b11110) begin
        wr_b0 = 1'b1;
        cnt_d = 2'd1;
        exp_d = 3'd4;
      end else begin
        tail_d    = 1'b1;
        tail_cp_d = ReplCp;
        tail_ok_d = 1'b0;
      end
    end
  end

  assign sts_o.plan_any = (rep_d != 3'd0) || tail_d;
  assign sts_o.pend_any = (rep_q != 3'd0) || tail_q;

  // next result from the plan: replacements first, then the tail
  assign res_cp   = (rep_q != 3'd0) ? ReplCp : tail_cp_q;
  assign res_ok   = (rep_q != 3'd0) ? 1'b0 : tail_ok_q;
  assign res_last = (rep_q != 3'd0) ? ((rep_q == 3'd1) && !tail_q) : 1'b1;

  assign dec_d  = (dec_q == '1) ? dec_q : dec_q + 1'b1;
  assign inv_d  = (res_ok || inv_q == '1) ? inv_q : inv_q + 1'b1;
  assign repl_d = (res_cp != ReplCp || repl_q == '1) ? repl_q : repl_q + 1'b1;
  assign dec_x  = 64'(dec_d);
  assign inv_x  = 64'(inv_d);
  assign repl_x = 64'(repl_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      exp_q  <= 3'd0;
      rep_q  <= 3'd0;
      tail_q <= 1'b0;
      dec_q  <= '0;
      inv_q  <= '0;
      repl_q <= '0;
    end else begin
      if (cmd_i.take) begin
        cnt_q  <= cnt_d;
        exp_q  <= exp_d;
        rep_q  <= rep_d;
        tail_q <= tail_d;
      end else if (cmd_i.load) begin
        if (rep_q != 3'd0) begin
          rep_q <= rep_q - 3'd1;
        end else begin
          tail_q <= 1'b0;
        end
        dec_q  <= dec_d;
        inv_q  <= inv_d;
        repl_q <= repl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      tail_cp_q <= tail_cp_d;
      tail_ok_q <= tail_ok_d;
      if (wr_b0) b0_q <= data_byte_i;
      if (wr_b1) b1_q <= data_byte_i;
      if (wr_b2) b2_q <= data_byte_i;
    end
    if (cmd_i.load) begin
      code_point_o        <= res_cp;
      well_formed_o       <= res_ok;
      glyph_code_o        <= glyph_of(res_cp);
      glyph_fallback_o    <= (glyph_of(res_cp) == 8'h00);
      last_of_run_o       <= res_last;
      decoded_total_o     <= dec_x[31:0];
      invalid_total_o     <= inv_x[31:0];
      replacement_total_o <= repl_x[31:0];
    end
  end

  a_plan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q <= 3'd4) else $error("more than four replacements planned");
  a_buf_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 || {1'b0, cnt_q} < exp_q) else $error("buffer count beyond length");
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && res_last |=> !sts_o.pend_any) else $error("results left after last");

endmodule

>>> design/utf8_decode_to_glyph.sv
// sequencing: an item is taken in the idle state; one that yields results passes through the
// load state to the show state, where its first result is shown, and each further result is
// loaded when the shown one is taken and appears in the next cycle; no new item is taken until
// the controller has sequenced the one output register through the whole result plan
// reset: buffer count, result plan and the saturating totals clear; no clearing pass
// utf8_decode_to_glyph: top level; depends on u8g_pkg, u8g_ctrl and u8g_dp
module utf8_decode_to_glyph import u8g_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [7:0]               s_axis_tdata_i,   // data_byte
  input  logic                     s_axis_tuser_i,   // op
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // code_point, glyph_code, decoded_total, invalid_total, replacement_total, zero pad
  output logic [TdataOutWidth-1:0] m_axis_tdata_o,
  output logic [1:0]               m_axis_tuser_o,   // well_formed, glyph_fallback
  output logic                     m_axis_tlast_o
);

  u8g_cmd_t    cmd;
  u8g_sts_t    sts;
  logic [20:0] code_point;
  logic        well_formed;
  logic [7:0]  glyph_code;
  logic        glyph_fallback;
  logic [31:0] decoded_total, invalid_total, replacement_total;

  u8g_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  u8g_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .op_i                (s_axis_tuser_i),
    .data_byte_i         (s_axis_tdata_i),
    .code_point_o        (code_point),
    .well_formed_o       (well_formed),
    .glyph_code_o        (glyph_code),
    .glyph_fallback_o    (glyph_fallback),
    .last_of_run_o       (m_axis_tlast_o),
    .decoded_total_o     (decoded_total),
    .invalid_total_o     (invalid_total),
    .replacement_total_o (replacement_total)
  );

  assign m_axis_tdata_o = {3'd0, replacement_total, invalid_total, decoded_total,
                           glyph_code, code_point};
  assign m_axis_tuser_o = {glyph_fallback, well_formed};

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for utf8_decode_to_glyph, directed table then random text
// depends on u8g_pkg and the utf8_decode_to_glyph rtl; predicts every result item
// and checks it in order with random stalls on both stream sides
module tb_top import u8g_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 354;
  localparam int QuietLimit  = 3000;
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic        op;
    logic [7:0]  b;
    logic        typed;
    logic [20:0] cp;
    logic        wf;
    logic [7:0]  gl;
    logic        fb;
  } stim_row_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        wf;
    logic [7:0]  gl;
    logic        fb;
    logic        last;
    logic [31:0] dec;
    logic [31:0] inv;
    logic [31:0] rep;
  } glyph_rec_t;

  localparam int NumDirected = 26;
  localparam stim_row_t Directed [NumDirected] = '{
    '{OpData,  8'h41, 1'b1, 21'h41,  1'b1, 8'h41, 1'b0},
    '{OpData,  8'h00, 1'b1, 21'h00,  1'b1, 8'h00, 1'b1},
    '{OpData,  8'h7F, 1'b1, 21'h7F,  1'b1, 8'h7F, 1'b0},
    '{OpData,  8'h80, 1'b1, ReplCp,  1'b0, 8'h00, 1'b1},
    '{OpData,  8'hFF, 1'b1, ReplCp,  1'b0, 8'h00, 1'b1},
    '{OpData,  8'hC3, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hA4, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hC0, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h80, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hED, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hA0, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h80, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hEF, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hBF, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hBD, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hF4, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h90, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h80, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h80, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hF0, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h9F, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h80, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'h41, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpData,  8'hE2, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0},
    '{OpFlush, 8'hA5, 1'b1, ReplCp,  1'b0, 8'h00, 1'b1},
    '{OpFlush, 8'h5A, 1'b0, 21'h0,   1'b0, 8'h00, 1'b0}
  };

  localparam logic [20:0] SpecialCps [14] = '{
    21'h00FFFD, 21'h00FFFE, 21'h00FFFF, 21'h00D800, 21'h00DFFF, 21'h00D7FF, 21'h00E000,
    21'h110000, 21'h1FFFFF, 21'h10FFFF, 21'h0007FF, 21'h000800, 21'h010000, 21'h000080
  };

  localparam logic [20:0] TableCps [7] = '{
    21'h0E4, 21'h0F6, 21'h0FC, 21'h0C4, 21'h0D6, 21'h0DC, 21'h0DF
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     s_axis_tvalid_i;
  logic                     s_axis_tready_o;
  logic [7:0]               s_axis_tdata_i;
  logic                     s_axis_tuser_i;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i;
  logic [TdataOutWidth-1:0] m_axis_tdata_o;
  logic [1:0]               m_axis_tuser_o;
  logic                     m_axis_tlast_o;

  utf8_decode_to_glyph DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  // decoder image
  logic [7:0]  lead_buf [3];
  logic [1:0]  buf_cnt;
  logic [2:0]  seq_len;
  logic [31:0] n_dec, n_inv, n_rep;
  int          step_n;
  glyph_rec_t  glyph_q [$];

  stim_row_t   item_row;
  int          in_gap;
  bit          in_calm;
  int          mismatches;
  int          quiet_cycles;

  function automatic logic [31:0] sat_bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [7:0] glyph_for(input logic [20:0] cp);
    if (cp < 21'h80) return cp[7:0];
    case (cp)
      21'h0E4: return 8'h84;
      21'h0F6: return 8'h94;
      21'h0FC: return 8'h81;
      21'h0C4: return 8'h8E;
      21'h0D6: return 8'h99;
      21'h0DC: return 8'h9A;
      21'h0DF: return 8'hE1;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic is_scalar(input logic [20:0] cp);
    return cp <= MaxScalar && !(cp >= SurLo && cp <= SurHi) &&
           cp != NonCharFe && cp != NonCharFf;
  endfunction

  task automatic emit_glyph(input logic [20:0] cp, input logic ok);
    glyph_rec_t r;
    if (step_n >= 4) return;
    if (!ok) n_inv = sat_bump(n_inv);
    if (cp == ReplCp) n_rep = sat_bump(n_rep);
    n_dec = sat_bump(n_dec);
    r.cp   = cp;
    r.wf   = ok;
    r.gl   = glyph_for(cp);
    r.fb   = (r.gl == 8'h00);
    r.last = 1'b0;
    r.dec  = n_dec;
    r.inv  = n_inv;
    r.rep  = n_rep;
    glyph_q.push_back(r);
    step_n++;
  endtask

  task automatic open_seq(input logic [7:0] b, input logic [2:0] len);
    lead_buf[0] = b;
    buf_cnt     = 2'd1;
    seq_len     = len;
  endtask

  task automatic take_lead(input logic [7:0] b);
    if (b < 8'h80) emit_glyph({13'd0, b}, 1'b1);
    else if (b[7:5] == 3'b110) open_seq(b, 3'd2);
    else if (b[7:4] == 4'b1110) open_seq(b, 3'd3);
    else if (b[7:3] == 5'b11110) open_seq(b, 3'd4);
    else emit_glyph(ReplCp, 1'b0);
  endtask

  task automatic drop_seq(input int cnt);
    for (int i = 0; i < cnt; i++) emit_glyph(ReplCp, 1'b0);
    buf_cnt = 2'd0;
    seq_len = 3'd0;
  endtask

  task automatic close_seq(input logic [7:0] b);
    logic [20:0] cp;
    logic        ok;
    if (seq_len == 3'd2) begin
      cp = {10'd0, lead_buf[0][4:0], b[5:0]};
      ok = cp >= Min2Byte;
    end else if (seq_len == 3'd3) begin
      cp = {5'd0, lead_buf[0][3:0], lead_buf[1][5:0], b[5:0]};
      ok = cp >= Min3Byte && is_scalar(cp);
    end else begin
      cp = {lead_buf[0][2:0], lead_buf[1][5:0], lead_buf[2][5:0], b[5:0]};
      ok = cp >= Min4Byte && is_scalar(cp);
    end
    if (ok) begin
      emit_glyph(cp, 1'b1);
      buf_cnt = 2'd0;
      seq_len = 3'd0;
    end else begin
      drop_seq(int'(seq_len));
    end
  endtask

  task automatic decode_byte(input logic op, input logic [7:0] b);
    logic busy;
    int   first;
    step_n = 0;
    first  = glyph_q.size();
    busy = seq_len >= 3'd2 && seq_len <= 3'd4 && buf_cnt >= 2'd1 &&
           {1'b0, buf_cnt} < seq_len;
    if (!busy) begin
      buf_cnt = 2'd0;
      seq_len = 3'd0;
    end
    if (op == OpFlush) begin
      if (busy) drop_seq(int'(buf_cnt));
    end else if (!busy) begin
      take_lead(b);
    end else if (b[7:6] == 2'b10) begin
      if ({1'b0, buf_cnt} + 3'd1 == seq_len) begin
        close_seq(b);
      end else begin
        lead_buf[buf_cnt] = b;
        buf_cnt = buf_cnt + 2'd1;
      end
    end else begin
      drop_seq(int'(buf_cnt));
      take_lead(b);
    end
    if (glyph_q.size() > first) glyph_q[glyph_q.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checking, prediction on accepted input items, idle watchdog
  always @(posedge clk_i) begin
    glyph_rec_t w;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (glyph_q.size() == 0) begin
          report_mismatch("unexpected item", {11'd0, m_axis_tdata_o[20:0]}, 32'd0);
        end else begin
          w = glyph_q.pop_front();
          if (m_axis_tdata_o[20:0] !== w.cp)
            report_mismatch("code_point", {11'd0, m_axis_tdata_o[20:0]}, {11'd0, w.cp});
          if (m_axis_tuser_o[0] !== w.wf)
            report_mismatch("well_formed", {31'd0, m_axis_tuser_o[0]}, {31'd0, w.wf});
          if (m_axis_tdata_o[28:21] !== w.gl)
            report_mismatch("glyph_code", {24'd0, m_axis_tdata_o[28:21]}, {24'd0, w.gl});
          if (m_axis_tuser_o[1] !== w.fb)
            report_mismatch("glyph_fallback", {31'd0, m_axis_tuser_o[1]}, {31'd0, w.fb});
          if (m_axis_tlast_o !== w.last)
            report_mismatch("last_of_run", {31'd0, m_axis_tlast_o}, {31'd0, w.last});
          if (m_axis_tdata_o[60:29] !== w.dec)
            report_mismatch("decoded_total", m_axis_tdata_o[60:29], w.dec);
          if (m_axis_tdata_o[92:61] !== w.inv)
            report_mismatch("invalid_total", m_axis_tdata_o[92:61], w.inv);
          if (m_axis_tdata_o[124:93] !== w.rep)
            report_mismatch("replacement_total", m_axis_tdata_o[124:93], w.rep);
          if (m_axis_tdata_o[127:125] !== 3'd0)
            report_mismatch("tdata pad", {29'd0, m_axis_tdata_o[127:125]}, 32'd0);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decode_byte(s_axis_tuser_i, s_axis_tdata_i);
        if (item_row.typed && glyph_q.size() > 0) begin
          glyph_q[glyph_q.size()-1].cp = item_row.cp;
          glyph_q[glyph_q.size()-1].wf = item_row.wf;
          glyph_q[glyph_q.size()-1].gl = item_row.gl;
          glyph_q[glyph_q.size()-1].fb = item_row.fb;
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("utf8_decode_to_glyph regression: fail");
    $finish;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    bit out_calm;
    int hold;
    int stall;
    m_axis_tready_i = 1'b0;
    out_calm        = 1'b0;
    forever begin
      m_axis_tready_i <= 1'b1;
      hold = out_calm ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (hold) @(posedge clk_i);
      if ($urandom_range(0, 7) == 0) out_calm = ~out_calm;
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic push_item(input stim_row_t row);
    if (in_gap > 0) repeat (in_gap) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= row.op;
    s_axis_tdata_i  <= row.b;
    item_row        <= row;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
    in_gap = pick_gap(in_calm);
    if (in_gap > 0) s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic send_byte(input logic op, input logic [7:0] b, inout int sent);
    stim_row_t row;
    row       = '0;
    row.op    = op;
    row.b     = b;
    push_item(row);
    sent++;
  endtask

  function automatic logic [31:0] utf8_encode(input logic [20:0] cp, input int n);
    case (n)
      1:       return {24'd0, 1'b0, cp[6:0]};
      2:       return {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      3:       return {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
    endcase
  endfunction

  function automatic int natural_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  initial begin
    int          sent;
    int          kind;
    int          n;
    int          keep;
    logic [20:0] cp;
    logic [31:0] seq;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = OpData;
    item_row        = '0;
    in_gap          = 0;
    in_calm         = 1'b0;
    mismatches      = 0;
    quiet_cycles    = 0;
    lead_buf        = '{8'h00, 8'h00, 8'h00};
    buf_cnt         = 2'd0;
    seq_len         = 3'd0;
    n_dec           = 32'd0;
    n_inv           = 32'd0;
    n_rep           = 32'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) push_item(Directed[i]);

    sent = 0;
    while (sent < RandomItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        case ($urandom_range(0, 9))
          0, 1, 2: cp = 21'($urandom_range(0, 8'h7F));
          3:       cp = TableCps[$urandom_range(0, 6)];
          4:       cp = 21'($urandom_range(21'h80, 21'h7FF));
          5:       cp = 21'($urandom_range(21'h800, 21'hFFFF));
          6:       cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
          7:       cp = SpecialCps[$urandom_range(0, 13)];
          default: cp = 21'($urandom_range(0, 21'h1FFFFF));
        endcase
        n = natural_len(cp);
        if ($urandom_range(0, 9) == 0 && n < 4) n = $urandom_range(n + 1, 4);
        seq  = utf8_encode(cp, n);
        keep = n;
        if (kind >= 60 && n > 1) keep = $urandom_range(1, n - 1);
        for (int k = 0; k < keep; k++) send_byte(OpData, seq[8*k +: 8], sent);
      end else if (kind < 90) begin
        send_byte(OpData, 8'($urandom_range(0, 255)), sent);
      end else begin
        send_byte(OpFlush, 8'($urandom_range(0, 255)), sent);
      end
    end

    if (in_gap == 0) s_axis_tvalid_i <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("utf8_decode_to_glyph regression: pass");
    else
      $display("utf8_decode_to_glyph regression: fail");
    $finish;
  end

endmodule

>>> sim.f
design/u8g_pkg.sv
design/u8g_ctrl.sv
design/u8g_dp.sv
design/utf8_decode_to_glyph.sv
tb/tb_top.sv
